// ===== src/strmq_pkg.sv =====
package strmq_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int VALUE_BITS   = 32;
	localparam int LEVELS       = 11;

	localparam int IDX_W     = $clog2(MAX_ELEMENTS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int RUN_W     = CNT_W + 1;
	localparam int LVL_W     = $clog2(LEVELS + 1);
	localparam int TBL_DEPTH = LEVELS * MAX_ELEMENTS;
	localparam int TBL_AW    = $clog2(TBL_DEPTH);

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_B_CHK,
		ST_B_RD,
		ST_B_EL,
		ST_B_WR,
		ST_Q_RD,
		ST_Q_EL,
		ST_Q_CMP
	} state_t;

	typedef struct packed {
		logic load_we;
		logic build_init;
		logic build_wr;
		logic build_done;
		logic sel_build;
		logic q_capture;
		logic res_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic lvl_ok;
		logic last_i;
		logic out_free;
	} ctrl_sts_t;

endpackage

// ===== src/strmq_ram.sv =====
module strmq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== src/strmq_ctrl.sv =====
module strmq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 cmd,
	input  logic                 is_last,
	input  strmq_pkg::ctrl_sts_t sts,
	output strmq_pkg::ctrl_cmd_t ctl
);

	strmq_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= strmq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		in_stall  = 1'b1;
		case (state_q)
			strmq_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (cmd == strmq_pkg::CMD_LOAD) begin
						ctl.load_we = 1'b1;
						if (is_last) begin
							ctl.build_init = 1'b1;
							state_nxt      = strmq_pkg::ST_B_CHK;
						end
					end else begin
						ctl.q_capture = 1'b1;
						state_nxt     = strmq_pkg::ST_Q_RD;
					end
				end
			end
			strmq_pkg::ST_B_CHK: begin
				ctl.sel_build = 1'b1;
				if (sts.lvl_ok) begin
					state_nxt = strmq_pkg::ST_B_RD;
				end else begin
					ctl.build_done = 1'b1;
					state_nxt      = strmq_pkg::ST_IDLE;
				end
			end
			strmq_pkg::ST_B_RD: begin
				ctl.sel_build = 1'b1;
				state_nxt     = strmq_pkg::ST_B_EL;
			end
			strmq_pkg::ST_B_EL: begin
				ctl.sel_build = 1'b1;
				state_nxt     = strmq_pkg::ST_B_WR;
			end
			strmq_pkg::ST_B_WR: begin
				ctl.sel_build = 1'b1;
				ctl.build_wr  = 1'b1;
				state_nxt     = sts.last_i ? strmq_pkg::ST_B_CHK : strmq_pkg::ST_B_RD;
			end
			strmq_pkg::ST_Q_RD: begin
				state_nxt = strmq_pkg::ST_Q_EL;
			end
			strmq_pkg::ST_Q_EL: begin
				state_nxt = strmq_pkg::ST_Q_CMP;
			end
			strmq_pkg::ST_Q_CMP: begin
				// memory outputs hold while the result register is still occupied
				if (sts.out_free) begin
					ctl.res_load = 1'b1;
					state_nxt    = strmq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = strmq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/strmq_dp.sv =====
module strmq_dp (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  strmq_pkg::ctrl_cmd_t                      ctl,
	output strmq_pkg::ctrl_sts_t                      sts,
	input  logic                                      is_last,
	input  logic [strmq_pkg::IDX_W-1:0]               elem_index,
	input  logic signed [strmq_pkg::VALUE_BITS-1:0]   elem_value,
	input  logic [strmq_pkg::IDX_W-1:0]               range_start,
	input  logic [strmq_pkg::IDX_W-1:0]               range_end,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic signed [strmq_pkg::VALUE_BITS-1:0]   min_value,
	output logic [strmq_pkg::IDX_W-1:0]               min_position,
	output logic                                      range_error
);

	logic [strmq_pkg::LVL_W-1:0] lvl_q;
	logic [strmq_pkg::IDX_W-1:0] i_q;
	logic [strmq_pkg::CNT_W-1:0] count_q;
	logic                        ready_q;
	logic [strmq_pkg::TBL_AW-1:0] qa_q, qb_q;
	logic                         err_q;

	logic                                    out_valid_q;
	logic signed [strmq_pkg::VALUE_BITS-1:0] min_value_q;
	logic [strmq_pkg::IDX_W-1:0]             min_position_q;
	logic                                    range_error_q;

	logic [strmq_pkg::RUN_W-1:0]  run, half;
	logic [strmq_pkg::LVL_W-1:0]  lvl_m1;
	logic [strmq_pkg::IDX_W-1:0]  i_b;
	logic [strmq_pkg::TBL_AW-1:0] tbl_ra, tbl_rb, tbl_wa;
	logic [strmq_pkg::IDX_W-1:0]  tbl_wd, tbl_a, tbl_b;
	logic                         tbl_we;
	logic signed [strmq_pkg::VALUE_BITS-1:0] val_a, val_b;
	logic [strmq_pkg::IDX_W-1:0]  pick_bld;
	logic                         q_left;

	logic [strmq_pkg::CNT_W-1:0]  q_len, q_rs;
	logic [strmq_pkg::LVL_W-1:0]  q_k;
	logic                         q_err;

	assign run    = strmq_pkg::RUN_W'(1) << lvl_q;
	assign half   = strmq_pkg::RUN_W'(1) << lvl_m1;
	assign lvl_m1 = lvl_q - strmq_pkg::LVL_W'(1);
	assign i_b    = strmq_pkg::IDX_W'(strmq_pkg::RUN_W'(i_q) + half);

	assign sts.lvl_ok   = (lvl_q <= strmq_pkg::LVL_W'(strmq_pkg::LEVELS - 1)) &&
	                      (run <= strmq_pkg::RUN_W'(count_q));
	assign sts.last_i   = (strmq_pkg::RUN_W'(i_q) + run) == strmq_pkg::RUN_W'(count_q);
	assign sts.out_free = !out_valid_q || !out_stall;

	// query setup: level, second run start and error flag from the range
	always_comb begin
		logic [strmq_pkg::LVL_W-1:0] k_raw;
		k_raw = '0;
		q_len = strmq_pkg::CNT_W'(range_end) - strmq_pkg::CNT_W'(range_start) +
		        strmq_pkg::CNT_W'(1);
		for (int b = 0; b < strmq_pkg::CNT_W; b++) begin
			if (q_len[b]) begin
				k_raw = strmq_pkg::LVL_W'(b);
			end
		end
		q_k = (k_raw > strmq_pkg::LVL_W'(strmq_pkg::LEVELS - 1)) ?
		      strmq_pkg::LVL_W'(strmq_pkg::LEVELS - 1) : k_raw;
		q_rs = strmq_pkg::CNT_W'(range_end) + strmq_pkg::CNT_W'(1) -
		       (strmq_pkg::CNT_W'(1) << q_k);
		q_err = !ready_q || (range_start > range_end) ||
		        (strmq_pkg::CNT_W'(range_end) >= count_q);
	end

	assign tbl_ra = ctl.sel_build ? strmq_pkg::TBL_AW'({lvl_m1, i_q}) : qa_q;
	assign tbl_rb = ctl.sel_build ? strmq_pkg::TBL_AW'({lvl_m1, i_b}) : qb_q;

	// level 0 holds the identity and is written along with each load
	assign tbl_we = ctl.load_we || ctl.build_wr;
	assign tbl_wa = ctl.build_wr ? strmq_pkg::TBL_AW'({lvl_q, i_q}) :
	                strmq_pkg::TBL_AW'({strmq_pkg::LVL_W'(0), elem_index});
	assign tbl_wd = ctl.build_wr ? pick_bld : elem_index;

	// build keeps the right half on a tie, query keeps the left run
	assign pick_bld = (val_a < val_b) ? tbl_a : tbl_b;
	assign q_left   = (val_a <= val_b);

	strmq_ram #(
		.WIDTH(strmq_pkg::IDX_W),
		.DEPTH(strmq_pkg::TBL_DEPTH)
	) u_tbl (
		.clk     (clk),
		.we      (tbl_we),
		.waddr   (tbl_wa),
		.wdata   (tbl_wd),
		.raddr_a (tbl_ra),
		.rdata_a (tbl_a),
		.raddr_b (tbl_rb),
		.rdata_b (tbl_b)
	);

	strmq_ram #(
		.WIDTH(strmq_pkg::VALUE_BITS),
		.DEPTH(strmq_pkg::MAX_ELEMENTS)
	) u_elem (
		.clk     (clk),
		.we      (ctl.load_we),
		.waddr   (elem_index),
		.wdata   (elem_value),
		.raddr_a (tbl_a),
		.rdata_a (val_a),
		.raddr_b (tbl_b),
		.rdata_b (val_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q   <= '0;
			i_q     <= '0;
			count_q <= '0;
			ready_q <= 1'b0;
		end else begin
			if (ctl.load_we) begin
				ready_q <= 1'b0;
				if (is_last) begin
					count_q <= strmq_pkg::CNT_W'(elem_index) + strmq_pkg::CNT_W'(1);
				end
			end
			if (ctl.build_init) begin
				lvl_q <= strmq_pkg::LVL_W'(1);
				i_q   <= '0;
			end
			if (ctl.build_wr) begin
				if (sts.last_i) begin
					lvl_q <= lvl_q + strmq_pkg::LVL_W'(1);
					i_q   <= '0;
				end else begin
					i_q <= i_q + strmq_pkg::IDX_W'(1);
				end
			end
			if (ctl.build_done) begin
				ready_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.q_capture) begin
			qa_q  <= strmq_pkg::TBL_AW'({q_k, range_start});
			qb_q  <= strmq_pkg::TBL_AW'({q_k, q_rs[strmq_pkg::IDX_W-1:0]});
			err_q <= q_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			range_error_q  <= err_q;
			min_value_q    <= err_q ? '0 : (q_left ? val_a : val_b);
			min_position_q <= err_q ? '0 : (q_left ? tbl_a : tbl_b);
		end
	end

	assign out_valid    = out_valid_q;
	assign min_value    = min_value_q;
	assign min_position = min_position_q;
	assign range_error  = range_error_q;

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.res_load |-> (!out_valid_q || !out_stall))
		else $error("pending result overwritten");

	a_build_level: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.build_wr |-> (lvl_q != '0) &&
		                 (lvl_q <= strmq_pkg::LVL_W'(strmq_pkg::LEVELS - 1)))
		else $error("build writes outside levels 1..LEVELS-1");

	a_load_clears_ready: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_we |=> !ready_q)
		else $error("table flag survives a load");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && range_error_q) |-> (min_value_q == '0) && (min_position_q == '0))
		else $error("error result carries nonzero fields");
`endif

endmodule

// ===== src/sparse_table_range_min_query_unit.sv =====
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   cmd elem_index elem_value is_last range_start range_end
// out      output     out_valid / out_stall min_value min_position range_error
//
// A load is written into the element memory and table level 0 as it is transferred. A query
// steps through transfer, table read at level k, element read of both candidate positions,
// and compare into the result register. A load marked last starts the build: per level a
// check, then per table entry a table read, an element read, and a compare and write; a final
// check ends it. in_stall stays high meanwhile.
// Reset clears the element count, the table flag and out_valid; the memories are not cleared.
// A query finishing while an earlier result is still held on a stalled out waits in its compare step.
module sparse_table_range_min_query_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic                                    cmd,
	input  logic [strmq_pkg::IDX_W-1:0]             elem_index,
	input  logic signed [strmq_pkg::VALUE_BITS-1:0] elem_value,
	input  logic                                    is_last,
	input  logic [strmq_pkg::IDX_W-1:0]             range_start,
	input  logic [strmq_pkg::IDX_W-1:0]             range_end,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [strmq_pkg::VALUE_BITS-1:0] min_value,
	output logic [strmq_pkg::IDX_W-1:0]             min_position,
	output logic                                    range_error
);

	strmq_pkg::ctrl_cmd_t ctl;
	strmq_pkg::ctrl_sts_t sts;

	strmq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.is_last  (is_last),
		.sts      (sts),
		.ctl      (ctl)
	);

	strmq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.is_last      (is_last),
		.elem_index   (elem_index),
		.elem_value   (elem_value),
		.range_start  (range_start),
		.range_end    (range_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.min_value    (min_value),
		.min_position (min_position),
		.range_error  (range_error)
	);

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

typedef struct {
	logic                                    cmd;
	logic [strmq_pkg::IDX_W-1:0]             elem_index;
	logic signed [strmq_pkg::VALUE_BITS-1:0] elem_value;
	logic                                    is_last;
	logic [strmq_pkg::IDX_W-1:0]             range_start;
	logic [strmq_pkg::IDX_W-1:0]             range_end;
} rmq_request_t;

typedef struct {
	logic signed [strmq_pkg::VALUE_BITS-1:0] value;
	logic [strmq_pkg::IDX_W-1:0]             position;
	logic                                    range_error;
} rmq_answer_t;

class range_min_scoreboard;
	logic signed [strmq_pkg::VALUE_BITS-1:0] elements [strmq_pkg::MAX_ELEMENTS];
	// min_pos[j][i]: position of the minimum over the 2^j elements starting at i
	logic [strmq_pkg::IDX_W-1:0]             min_pos [strmq_pkg::LEVELS][strmq_pkg::MAX_ELEMENTS];
	int unsigned                             count;
	bit                                      ready;
	rmq_answer_t                             pending_minima [$];
	int                                      mismatches;

	function new();
		count      = 0;
		ready      = 1'b0;
		mismatches = 0;
	endfunction

	function void rebuild_positions();
		int unsigned run, half;
		logic [strmq_pkg::IDX_W-1:0] lp, rp;
		for (int i = 0; i < int'(count); i++)
			min_pos[0][i] = strmq_pkg::IDX_W'(i);
		for (int j = 1; j < strmq_pkg::LEVELS; j++) begin
			run  = 1 << j;
			half = run >> 1;
			if (run > count)
				break;
			for (int i = 0; i + run <= count; i++) begin
				lp = min_pos[j-1][i];
				rp = min_pos[j-1][i+half];
				// equal halves keep the right position
				min_pos[j][i] = (elements[lp] < elements[rp]) ? lp : rp;
			end
		end
	endfunction

	function void note_transfer(rmq_request_t req);
		rmq_answer_t ans;
		int unsigned len, k, s, e;
		logic [strmq_pkg::IDX_W-1:0] lp, rp, pick;
		if (req.cmd == strmq_pkg::CMD_LOAD) begin
			elements[req.elem_index] = req.elem_value;
			ready = 1'b0;
			if (req.is_last) begin
				count = 32'(req.elem_index) + 1;
				rebuild_positions();
				ready = 1'b1;
			end
			return;
		end
		s = 32'(req.range_start);
		e = 32'(req.range_end);
		if (!ready || s > e || e >= count) begin
			ans.value       = '0;
			ans.position    = '0;
			ans.range_error = 1'b1;
		end else begin
			len = e - s + 1;
			k   = 0;
			while (((len >> 1) >> k) != 0)
				k++;
			if (k > strmq_pkg::LEVELS - 1)
				k = strmq_pkg::LEVELS - 1;
			lp   = min_pos[k][s];
			rp   = min_pos[k][e + 1 - (1 << k)];
			// equal runs keep the left position
			pick = (elements[lp] <= elements[rp]) ? lp : rp;
			ans.value       = elements[pick];
			ans.position    = pick;
			ans.range_error = 1'b0;
		end
		pending_minima.push_back(ans);
	endfunction

	function void check_result(rmq_answer_t got);
		rmq_answer_t want;
		if (pending_minima.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t unexpected result: value %0d position %0d error %0b",
					$time, got.value, got.position, got.range_error);
			return;
		end
		want = pending_minima.pop_front();
		if (got.value !== want.value || got.position !== want.position ||
				got.range_error !== want.range_error) begin
			mismatches++;
			if (mismatches <= 10) begin
				$write("%0t mismatch: expected value %0d position %0d error %0b, ", $time,
					want.value, want.position, want.range_error);
				$display("got value %0d position %0d error %0b",
					got.value, got.position, got.range_error);
			end
		end
	endfunction
endclass

module tb_top;
	localparam int QUIET_LIMIT = 150000;
	localparam int ITEM_TARGET = 1700;
	localparam int HOLD_CYCLES = 400;

	logic                                    clk;
	logic                                    arst_n;
	logic                                    in_valid;
	logic                                    in_stall;
	logic                                    cmd;
	logic [strmq_pkg::IDX_W-1:0]             elem_index;
	logic signed [strmq_pkg::VALUE_BITS-1:0] elem_value;
	logic                                    is_last;
	logic [strmq_pkg::IDX_W-1:0]             range_start;
	logic [strmq_pkg::IDX_W-1:0]             range_end;
	logic                                    out_valid;
	logic                                    out_stall;
	logic signed [strmq_pkg::VALUE_BITS-1:0] min_value;
	logic [strmq_pkg::IDX_W-1:0]             min_position;
	logic                                    range_error;

	range_min_scoreboard sb = new();

	bit          written [strmq_pkg::MAX_ELEMENTS];
	int unsigned cur_count;
	bit          cur_ready;
	int          items_sent;
	bit          idle_on;
	int          gap_pct;
	int          stall_pct;
	bit          hold_request;
	int          quiet_cycles = 0;

	sparse_table_range_min_query_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : receiver
		int hold;
		bit hold_taken;
		out_stall  = 1'b0;
		hold       = 0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				hold       = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 99) < stall_pct) begin
				hold       = $urandom_range(1, 18) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// result checking and watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result('{min_value, min_position, range_error});
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("RESULT: ERROR");
					$finish;
				end
			end
		end
	end

	// called and returns at a falling edge
	task automatic send_item(rmq_request_t req);
		if (idle_on && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= req.cmd;
		elem_index  <= req.elem_index;
		elem_value  <= req.elem_value;
		is_last     <= req.is_last;
		range_start <= req.range_start;
		range_end   <= req.range_end;
		do @(posedge clk); while (in_stall);
		sb.note_transfer(req);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic load_element(int unsigned idx, logic signed [strmq_pkg::VALUE_BITS-1:0] val,
			bit last);
		rmq_request_t req;
		req.cmd         = strmq_pkg::CMD_LOAD;
		req.elem_index  = strmq_pkg::IDX_W'(idx);
		req.elem_value  = val;
		req.is_last     = last;
		req.range_start = strmq_pkg::IDX_W'($urandom);
		req.range_end   = strmq_pkg::IDX_W'($urandom);
		send_item(req);
		written[idx] = 1'b1;
		cur_ready    = last;
		if (last)
			cur_count = idx + 1;
	endtask

	task automatic run_query(int unsigned s, int unsigned e);
		rmq_request_t req;
		req.cmd         = strmq_pkg::CMD_QUERY;
		req.elem_index  = strmq_pkg::IDX_W'($urandom);
		req.elem_value  = $urandom;
		req.is_last     = 1'($urandom);
		req.range_start = strmq_pkg::IDX_W'(s);
		req.range_end   = strmq_pkg::IDX_W'(e);
		send_item(req);
	endtask

	// small values give plenty of ties
	function automatic logic signed [strmq_pkg::VALUE_BITS-1:0] rand_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return int'($urandom_range(0, 6)) - 3;
			4:          return {1'b1, {(strmq_pkg::VALUE_BITS-1){1'b0}}};
			5:          return {1'b0, {(strmq_pkg::VALUE_BITS-1){1'b1}}};
			default:    return $urandom;
		endcase
	endfunction

	function automatic int unsigned loaded_prefix();
		for (int i = 0; i < strmq_pkg::MAX_ELEMENTS; i++)
			if (!written[i])
				return i;
		return strmq_pkg::MAX_ELEMENTS;
	endfunction

	// loads 0..n-2 in shuffled order with a few stray loads, then n-1 as last
	task automatic full_build(int unsigned n);
		int unsigned order [];
		int unsigned j, tmp;
		order = new[n - 1];
		for (int i = 0; i < int'(n) - 1; i++)
			order[i] = i;
		for (int i = int'(n) - 2; i > 0; i--) begin
			j        = $urandom_range(0, i);
			tmp      = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		foreach (order[i]) begin
			if ($urandom_range(0, 99) < 5)
				load_element($urandom_range(0, strmq_pkg::MAX_ELEMENTS - 1), rand_value(), 1'b0);
			load_element(order[i], rand_value(), 1'b0);
		end
		load_element(n - 1, rand_value(), 1'b1);
	endtask

	task automatic random_query();
		int unsigned sel, s, e, len;
		sel = $urandom_range(0, 99);
		if (!cur_ready || sel < 8) begin
			s = $urandom_range(0, strmq_pkg::MAX_ELEMENTS - 1);
			e = $urandom_range(0, strmq_pkg::MAX_ELEMENTS - 1);
		end else if (sel < 14) begin
			s = $urandom_range(1, strmq_pkg::MAX_ELEMENTS - 1);
			e = $urandom_range(0, s - 1);
		end else if (sel < 18 && cur_count < strmq_pkg::MAX_ELEMENTS) begin
			s = $urandom_range(0, cur_count - 1);
			e = $urandom_range(cur_count, strmq_pkg::MAX_ELEMENTS - 1);
		end else if (sel < 24) begin
			s = 0;
			e = cur_count - 1;
		end else begin
			s = $urandom_range(0, cur_count - 1);
			e = $urandom_range(s, cur_count - 1);
			if (sel < 50) begin
				len = 1 << $urandom_range(0, strmq_pkg::LEVELS - 1);
				if (s + len <= cur_count)
					e = s + len - 1;
			end
		end
		run_query(s, e);
	endtask

	initial begin : stimulus
		int unsigned nq, round, top;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		cmd          = strmq_pkg::CMD_LOAD;
		elem_index   = '0;
		elem_value   = '0;
		is_last      = 1'b0;
		range_start  = '0;
		range_end    = '0;
		idle_on      = 1'b1;
		gap_pct      = 20;
		stall_pct    = 20;
		hold_request = 1'b0;
		items_sent   = 0;
		cur_count    = 0;
		cur_ready    = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_query(0, 0);                          // no table yet
		load_element(0, 5, 1'b0);
		load_element(1, {1'b1, {(strmq_pkg::VALUE_BITS-1){1'b0}}}, 1'b0);
		load_element(2, {1'b0, {(strmq_pkg::VALUE_BITS-1){1'b1}}}, 1'b0);
		load_element(3, {1'b1, {(strmq_pkg::VALUE_BITS-1){1'b0}}}, 1'b0);
		load_element(4, 7, 1'b0);
		load_element(5, 7, 1'b0);
		load_element(6, 7, 1'b0);
		load_element(7, 0, 1'b1);
		run_query(0, 7);
		run_query(0, 0);
		run_query(7, 7);
		run_query(0, 3);                          // build tie: right half
		run_query(1, 3);                          // query tie: left run
		run_query(4, 6);
		run_query(2, 2);
		run_query(5, 4);                          // start past end
		run_query(0, 8);                          // end past count
		run_query(strmq_pkg::MAX_ELEMENTS - 1, strmq_pkg::MAX_ELEMENTS - 1);
		load_element(7, 1, 1'b0);                 // drops the table
		run_query(0, 7);

		round = 0;
		while (items_sent < ITEM_TARGET) begin
			round++;
			idle_on   = items_sent < ITEM_TARGET * 85 / 100;
			gap_pct   = (round % 4 == 0) ? 0 : $urandom_range(5, 40);
			stall_pct = (round % 5 == 1) ? 0 : $urandom_range(5, 40);
			nq        = $urandom_range(5, 40);
			if (round == 2) begin
				full_build(strmq_pkg::MAX_ELEMENTS);
				nq = 150;
			end else if ($urandom_range(0, 99) < 25) begin
				// rebuild over the already loaded prefix
				top = loaded_prefix();
				if (top > strmq_pkg::MAX_ELEMENTS - 1)
					top = strmq_pkg::MAX_ELEMENTS - 1;
				load_element($urandom_range(0, top), rand_value(), 1'b1);
			end else begin
				full_build($urandom_range(1, ($urandom_range(0, 9) == 0) ? 80 : 16));
			end
			if (round == 3) begin
				// long output hold while queries keep coming
				gap_pct      = 0;
				nq           = 40;
				hold_request = 1'b1;
			end
			repeat (nq) begin
				if ($urandom_range(0, 99) < 4)
					load_element($urandom_range(0, strmq_pkg::MAX_ELEMENTS - 1), rand_value(),
						1'b0);
				random_query();
			end
		end
		in_valid <= 1'b0;

		while (sb.pending_minima.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
